// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on: a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/pae_pkg.sv =====
// Shared constants for the positional array engine.
// Depends on: nothing.
package pae_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 7;
  localparam int STAT_W       = 2;
  localparam int ECNT_W       = 7;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_POS  = 2'd2;

endpackage

// ===== design/positional_array_engine_unit.sv =====
// Top level of the positional array engine: control sequencer over one entry RAM.
// Depends on: pae_pkg, pae_ram, assert_macros.svh.
//
// Append, overwrite, rejected commands and commands with nothing to move give
// their result in the cycle after start. Insert and delete that move entries
// walk them through the RAM one per cycle. Sort runs bubble passes through the
// single read port until a pass makes no swap. Search is a sort plus a scan of
// the entries. Dump gives one result per cycle. Results are shown for one cycle
// under strobe and cannot be held off; busy stays high until the final result
// (last high) is out, and start is taken again in that cycle.
`include "assert_macros.svh"

module positional_array_engine_unit import pae_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  output logic                     strobe,
  output logic [STAT_W-1:0]        status,
  output logic                     found,
  output logic signed [WORD_W-1:0] entry_value,
  output logic [ECNT_W-1:0]        entry_count,
  output logic                     last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1;
  localparam logic [2:0] S_DN    = 3'd2;
  localparam logic [2:0] S_SORT  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DUMP  = 3'd5;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     ridx, ridx_next;
  logic [AW-1:0]     stop, stop_next;
  logic              rd_more, rd_more_next;
  logic              pend, pend_next;
  logic [AW-1:0]     pend_idx, pend_idx_next;
  logic [WORD_W-1:0] val, val_next;
  logic [WORD_W-1:0] carry, carry_next;
  logic              swapped, swapped_next;
  logic              is_search, is_search_next;
  logic              hit, hit_next;

  logic              strobe_next, found_next, last_next;
  logic [STAT_W-1:0] status_next;
  logic [WORD_W-1:0] ev_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  logic [XW-1:0]     px, cx;
  logic              full, done;

  pae_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ridx),
    .rdata (rdata)
  );

  assign px   = XW'(position);
  assign cx   = XW'(count);
  assign full = (count == CW'(CAPACITY));
  assign done = !rd_more && !pend;
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    ridx_next      = ridx;
    stop_next      = stop;
    rd_more_next   = rd_more;
    pend_next      = 1'b0;
    pend_idx_next  = pend_idx;
    val_next       = val;
    carry_next     = carry;
    swapped_next   = swapped;
    is_search_next = is_search;
    hit_next       = hit;
    strobe_next    = 1'b0;
    status_next    = ST_OK;
    found_next     = 1'b0;
    ev_next        = '0;
    last_next      = 1'b1;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;

    if (state != S_IDLE && rd_more) begin
      pend_next     = 1'b1;
      pend_idx_next = ridx;
      if (ridx == stop) begin
        rd_more_next = 1'b0;
      end else if (state == S_UP) begin
        ridx_next = ridx - AW'(1);
      end else begin
        ridx_next = ridx + AW'(1);
      end
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (command) inside
            CMD_APPEND: begin
              strobe_next = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = AW'(count);
                wdata      = value;
                count_next = count + CW'(1);
              end
            end
            CMD_INSERT: begin
              if (px == '0 || px > cx + XW'(1)) begin
                strobe_next = 1'b1;
                status_next = ST_POS;
              end else if (full) begin
                strobe_next = 1'b1;
                status_next = ST_FULL;
              end else if (px == cx + XW'(1)) begin
                strobe_next = 1'b1;
                we          = 1'b1;
                waddr       = AW'(count);
                wdata       = value;
                count_next  = count + CW'(1);
              end else begin
                state_next   = S_UP;
                ridx_next    = AW'(count - CW'(1));
                stop_next    = AW'(px - XW'(1));
                rd_more_next = 1'b1;
                val_next     = value;
              end
            end
            CMD_DELETE: begin
              if (px == '0 || px > cx) begin
                strobe_next = 1'b1;
                status_next = ST_POS;
              end else if (px == cx) begin
                strobe_next = 1'b1;
                count_next  = count - CW'(1);
              end else begin
                state_next   = S_DN;
                ridx_next    = AW'(px);
                stop_next    = AW'(count - CW'(1));
                rd_more_next = 1'b1;
              end
            end
            CMD_WRITE: begin
              strobe_next = 1'b1;
              if (px == '0 || px > cx) begin
                status_next = ST_POS;
              end else begin
                we    = 1'b1;
                waddr = AW'(px - XW'(1));
                wdata = value;
              end
            end
            CMD_SORT, CMD_SEARCH: begin
              val_next       = value;
              is_search_next = (command == CMD_SEARCH);
              hit_next       = 1'b0;
              ridx_next      = '0;
              stop_next      = AW'(count - CW'(1));
              if (count > CW'(1)) begin
                state_next   = S_SORT;
                rd_more_next = 1'b1;
                swapped_next = 1'b0;
              end else if (command == CMD_SEARCH && count == CW'(1)) begin
                state_next   = S_SCAN;
                rd_more_next = 1'b1;
              end else begin
                strobe_next = 1'b1;
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                strobe_next = 1'b1;
              end else begin
                state_next   = S_DUMP;
                ridx_next    = '0;
                stop_next    = AW'(count - CW'(1));
                rd_more_next = 1'b1;
              end
            end
            default: begin
              strobe_next = 1'b1;
            end
          endcase
        end
      end
      S_UP: begin
        if (pend) begin
          we    = 1'b1;
          waddr = pend_idx + AW'(1);
          wdata = rdata;
        end else if (done) begin
          we          = 1'b1;
          waddr       = stop;
          wdata       = val;
          count_next  = count + CW'(1);
          strobe_next = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_DN: begin
        if (pend) begin
          we    = 1'b1;
          waddr = pend_idx - AW'(1);
          wdata = rdata;
        end else if (done) begin
          count_next  = count - CW'(1);
          strobe_next = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SORT: begin
        if (pend) begin
          if (pend_idx == '0) begin
            carry_next = rdata;
          end else if ($signed(rdata) < $signed(carry)) begin
            we           = 1'b1;
            waddr        = pend_idx - AW'(1);
            wdata        = rdata;
            swapped_next = 1'b1;
          end else begin
            we         = 1'b1;
            waddr      = pend_idx - AW'(1);
            wdata      = carry;
            carry_next = rdata;
          end
        end else if (done) begin
          we        = 1'b1;
          waddr     = stop;
          wdata     = carry;
          ridx_next = '0;
          if (swapped) begin
            rd_more_next = 1'b1;
            swapped_next = 1'b0;
          end else if (is_search) begin
            state_next   = S_SCAN;
            rd_more_next = 1'b1;
          end else begin
            strobe_next = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (pend) begin
          if (rdata == val) begin
            hit_next = 1'b1;
          end
        end else if (done) begin
          strobe_next = 1'b1;
          found_next  = hit;
          state_next  = S_IDLE;
        end
      end
      S_DUMP: begin
        if (pend) begin
          strobe_next = 1'b1;
          ev_next     = rdata;
          last_next   = (pend_idx == stop);
          if (pend_idx == stop) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_more <= 1'b0;
      pend    <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_more <= rd_more_next;
      pend    <= pend_next;
      strobe  <= strobe_next;
    end
    ridx        <= ridx_next;
    stop        <= stop_next;
    pend_idx    <= pend_idx_next;
    val         <= val_next;
    carry       <= carry_next;
    swapped     <= swapped_next;
    is_search   <= is_search_next;
    hit         <= hit_next;
    status      <= status_next;
    found       <= found_next;
    entry_value <= ev_next;
    entry_count <= ECNT_W'(count_next);
    last        <= last_next;
  end

  `ASSERT_NEVER(a_count_cap, count > CW'(CAPACITY), "live count above capacity")
  `ASSERT_CLK(a_mid_dump, strobe && !last |-> state == S_DUMP, "non-final item outside dump")
  `ASSERT_CLK(a_last_free, strobe && last |-> !busy, "busy after final item")

endmodule

// ===== design/pae_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on: nothing.
module pae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
